/* rtl/vsa_pkg.sv */
// ----------------------------------------------------------------------------
// vsa_pkg: shared types and constants
// Item formats, operation and status codes, table geometry, priority encoder.
// ----------------------------------------------------------------------------
package vsa_pkg;

  // Table geometry: the free map is kept as rows of single-bit flags.
  localparam int IdxW     = 10;
  localparam int VerW     = 32;
  localparam int MaxSlots = 1 << IdxW;
  localparam int HwW      = IdxW + 1;
  localparam int ColW     = 5;
  localparam int RowW     = IdxW - ColW;
  localparam int Cols     = 1 << ColW;
  localparam int Rows     = 1 << RowW;

  // Operation codes
  localparam logic [1:0] KindCreate = 2'd0;
  localparam logic [1:0] KindDelete = 2'd1;
  localparam logic [1:0] KindCheck  = 2'd2;
  localparam logic [1:0] KindLookup = 2'd3;

  // Status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] slot_index;
    logic [VerW-1:0] handle_version;
  } vsa_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] out_index;
    logic [VerW-1:0] out_version;
    logic            handle_ok;
  } vsa_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // capture item, launch memory reads
    logic execute;  // update state, load output register
  } vsa_cmd_t;

  // Index of the lowest set bit (0 when none is set).
  function automatic logic [ColW-1:0] lowest_set(input logic [Cols-1:0] vec);
    logic [ColW-1:0] pos;
    pos = '0;
    for (int i = Cols - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = ColW'(i);
      end
    end
    return pos;
  endfunction

  // Same encoder for the row summary vector.
  function automatic logic [RowW-1:0] lowest_row(input logic [Rows-1:0] vec);
    logic [RowW-1:0] pos;
    pos = '0;
    for (int i = Rows - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = RowW'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* rtl/vsa_ctrl.sv */
// ----------------------------------------------------------------------------
// vsa_ctrl: handshake and sequencing
// Two-state sequencer; owns the output valid flag.
// ----------------------------------------------------------------------------
module vsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vsa_pkg::vsa_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, execute, out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == StIdle) && in_valid_i;
  assign execute  = (state_q == StExec) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (execute) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (execute) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.accept  = accept;
  assign cmd_o.execute = execute;

  // An accepted item always moves on to execution.
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StExec)
    else $error("accepted item did not enter execution");

  // Execution waits while a previous result is held back.
  a_exec_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && out_valid_q && out_stall_i) |=> state_q == StExec)
    else $error("result register overwritten while stalled");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

/* rtl/vsa_datapath.sv */
// ----------------------------------------------------------------------------
// vsa_datapath: slot tables and result logic
// Version memory, row-organized free map with row summary, high-water mark,
// version counter and the output register.
// ----------------------------------------------------------------------------
module vsa_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vsa_pkg::vsa_cmd_t cmd_i,
  input  vsa_pkg::vsa_in_t  in_item_i,
  output vsa_pkg::vsa_out_t out_item_o
);

  // Storage
  logic [vsa_pkg::VerW-1:0] ver_mem [vsa_pkg::MaxSlots];
  logic [vsa_pkg::Cols-1:0] free_mem [vsa_pkg::Rows];
  logic [vsa_pkg::Rows-1:0] row_vld_q;  // row holds written data
  logic [vsa_pkg::Rows-1:0] summ_q;     // row has a free slot
  logic [vsa_pkg::HwW-1:0]  hw_q, hw_d;
  logic [vsa_pkg::VerW-1:0] next_ver_q, next_ver_d;

  // Captured item and read data
  vsa_pkg::vsa_in_t         item_q;
  logic                     found_q;
  logic [vsa_pkg::RowW-1:0] row_addr_q;
  logic                     row_vld_rd_q;
  logic [vsa_pkg::Cols-1:0] row_rd_q;
  logic [vsa_pkg::VerW-1:0] ver_rd_q;
  vsa_pkg::vsa_out_t        out_q, out_d;

  logic [vsa_pkg::RowW-1:0] row_addr;
  logic [vsa_pkg::Cols-1:0] row_eff, row_new;
  logic [vsa_pkg::ColW-1:0] col_free, col_idx;
  logic                     row_we, ver_we;
  logic [vsa_pkg::IdxW-1:0] ver_waddr;
  logic                     in_range, valid, is_top, hw_full;

  // Create reads the lowest row with a free slot, others the row of the index
  assign row_addr = (in_item_i.kind == vsa_pkg::KindCreate)
                  ? vsa_pkg::lowest_row(summ_q)
                  : in_item_i.slot_index[vsa_pkg::IdxW-1 -: vsa_pkg::RowW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q       <= in_item_i;
      found_q      <= |summ_q;
      row_addr_q   <= row_addr;
      row_vld_rd_q <= row_vld_q[row_addr];
      row_rd_q     <= free_mem[row_addr];
      ver_rd_q     <= ver_mem[in_item_i.slot_index];
    end
    if (row_we) begin
      free_mem[row_addr_q] <= row_new;
    end
    if (ver_we) begin
      ver_mem[ver_waddr] <= next_ver_q;
    end
    if (cmd_i.execute) begin
      out_q <= out_d;
    end
  end

  assign row_eff  = row_vld_rd_q ? row_rd_q : '0;
  assign col_free = vsa_pkg::lowest_set(row_eff);
  assign col_idx  = item_q.slot_index[vsa_pkg::ColW-1:0];
  assign in_range = {1'b0, item_q.slot_index} < hw_q;
  assign valid    = in_range && !row_eff[col_idx] && (ver_rd_q == item_q.handle_version);
  assign is_top   = (vsa_pkg::HwW'(item_q.slot_index) + vsa_pkg::HwW'(1)) == hw_q;
  assign hw_full  = hw_q == vsa_pkg::HwW'(vsa_pkg::MaxSlots);

  always_comb begin
    out_d.status      = vsa_pkg::StatusOk;
    out_d.out_index   = item_q.slot_index;
    out_d.out_version = '0;
    out_d.handle_ok   = valid;
    row_we            = 1'b0;
    row_new           = row_eff;
    ver_we            = 1'b0;
    ver_waddr         = hw_q[vsa_pkg::IdxW-1:0];
    hw_d              = hw_q;
    next_ver_d        = next_ver_q;
    case (item_q.kind)
      vsa_pkg::KindCreate: begin
        out_d.handle_ok = 1'b1;
        if (found_q) begin
          // reuse lowest freed slot
          ver_waddr         = {row_addr_q, col_free};
          row_new[col_free] = 1'b0;
          row_we            = cmd_i.execute;
          ver_we            = cmd_i.execute;
        end else if (!hw_full) begin
          hw_d   = hw_q + vsa_pkg::HwW'(1);
          ver_we = cmd_i.execute;
        end else begin
          out_d.status    = vsa_pkg::StatusFull;
          out_d.handle_ok = 1'b0;
        end
        if (out_d.handle_ok) begin
          out_d.out_index   = ver_waddr;
          out_d.out_version = next_ver_q;
          next_ver_d        = next_ver_q + vsa_pkg::VerW'(1);
        end
      end
      vsa_pkg::KindDelete: begin
        if (!valid) begin
          out_d.status = vsa_pkg::StatusInvalid;
        end else if (is_top) begin
          hw_d = hw_q - vsa_pkg::HwW'(1);
        end else begin
          row_new[col_idx] = 1'b1;
          row_we           = cmd_i.execute;
        end
      end
      vsa_pkg::KindLookup: begin
        if (in_range) begin
          out_d.out_version = ver_rd_q;
        end
      end
      default: ;  // check: validity only
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q       <= '0;
      next_ver_q <= vsa_pkg::VerW'(1);
      row_vld_q  <= '0;
      summ_q     <= '0;
    end else if (cmd_i.execute) begin
      hw_q       <= hw_d;
      next_ver_q <= next_ver_d;
      if (row_we) begin
        row_vld_q[row_addr_q] <= 1'b1;
        summ_q[row_addr_q]    <= |row_new;
      end
    end
  end

  assign out_item_o = out_q;

  a_hw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= vsa_pkg::HwW'(vsa_pkg::MaxSlots))
    else $error("high-water mark beyond table size");

  a_summ_rows_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (summ_q & ~row_vld_q) == '0)
    else $error("free summary set for unwritten row");

  a_version_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && item_q.kind == vsa_pkg::KindCreate && out_d.handle_ok)
    |=> next_ver_q == $past(next_ver_q) + vsa_pkg::VerW'(1))
    else $error("version counter did not advance on create");

endmodule

/* rtl/versioned_slot_allocator_top.sv */
// Timing: accept registers the item and its read data; execute loads the
//   result register, held back while an earlier result waits on out_stall_i.
// Items do not overlap: a new item waits for the read-then-update of the
//   version memory and free-map row memory (one port each).
// Reset: async active low; mark and version counter cleared (counter to 1),
//   free-map rows read as empty via per-row flags; no clearing pass.
// ----------------------------------------------------------------------------
// versioned_slot_allocator_top: generational slot handle allocator
// Create, delete, check and lookup of index+version handles over a
// 1024-slot table.
// ----------------------------------------------------------------------------
module versioned_slot_allocator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vsa_pkg::vsa_in_t  in_item_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vsa_pkg::vsa_out_t out_item_o
);

  vsa_pkg::vsa_cmd_t cmd;

  // Sequencer: idle -> execute, waits in execute while the result register
  // still holds an untaken item. Input is stalled outside idle.
  vsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: accept cycle captures the item and reads the version entry and
  // one free-map row (the lowest row with a free slot for create); execute
  // cycle resolves validity, writes back and loads the result register.
  vsa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
